[hw/rtl/lbr_pkg.sv]
// Shared types and constants for the LSB-first bit reader.
// No dependencies; lbr_ctrl and the top level import this package.
package lbr_pkg;

  // Byte index within one read window; covers up to nine bytes.
  localparam int K_W = 4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_ALIGN = 2'd2,
    ACT_RESET = 2'd3
  } lbr_act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_SHORT     = 2'd2,
    ST_FULL      = 2'd3
  } lbr_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_FIN  = 2'd2
  } lbr_state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic           in_ready;
    logic           rd_en;
    logic [K_W-1:0] rd_k;
    logic           rcv_en;
    logic [K_W-1:0] rcv_k;
    logic           commit;
  } lbr_ctl_t;

endpackage

[hw/rtl/lbr_if.sv]
// Valid/ready channel interfaces for the bit reader: input word and result word.
// No dependencies.
interface lbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [6:0] bit_count;
  logic       clear_buffer;

  modport source (output valid, action, data_byte, bit_count, clear_buffer, input ready);
  modport sink   (input valid, action, data_byte, bit_count, clear_buffer, output ready);
endinterface

interface lbr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic [11:0] available_bits;

  modport source (output valid, read_value, status, available_bits, input ready);
  modport sink   (input valid, read_value, status, available_bits, output ready);
endinterface

[hw/rtl/lbr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/lbr_ctrl.sv]
// Sequencer of the bit reader: accept, byte-fetch loop over the RAM, commit.
// Depends on lbr_pkg.
module lbr_ctrl
  import lbr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           go_read,    // accepted word is a read that will succeed
  input  logic [K_W-1:0] need_i,     // bytes the latched read spans
  input  logic           slot_free,  // result register can take a word
  output lbr_ctl_t       ctl
);

  lbr_state_t     st_r, st_nxt;
  logic [K_W-1:0] iss_r, iss_nxt;
  logic [K_W-1:0] rcv_r, rcv_nxt;
  logic           pend_r, pend_nxt;
  logic           in_fire;

  assign in_fire = in_valid && ctl.in_ready;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = go_read ? S_READ : S_FIN;
        end
      end
      S_READ: begin
        if (pend_r && (rcv_r == need_i - K_W'(1))) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl = '0;
    ctl.rd_k  = iss_r;
    ctl.rcv_k = rcv_r;
    case (st_r)
      S_IDLE: ctl.in_ready = 1'b1;
      S_READ: begin
        ctl.rd_en  = (iss_r != need_i);
        ctl.rcv_en = pend_r;
      end
      S_FIN:  ctl.commit = slot_free;
      default: ctl = '0;
    endcase
  end

  // Fetch counters: issued reads and returned bytes
  always_comb begin
    iss_nxt  = iss_r;
    rcv_nxt  = rcv_r;
    pend_nxt = ctl.rd_en;
    if (st_r == S_IDLE) begin
      iss_nxt = '0;
      rcv_nxt = '0;
    end else begin
      if (ctl.rd_en) begin
        iss_nxt = iss_r + K_W'(1);
      end
      if (ctl.rcv_en) begin
        rcv_nxt = rcv_r + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      iss_r  <= '0;
      rcv_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      iss_r  <= iss_nxt;
      rcv_r  <= rcv_nxt;
      pend_r <= pend_nxt;
    end
  end

  // A read window always spans at least one byte, else the loop never ends
  a_need_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_READ |-> need_i != '0)
    else $error("read loop entered with empty window");

  // Never issue past the window
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_READ |-> iss_r <= need_i)
    else $error("byte fetch issued beyond window");

  // A returned byte always belongs to an earlier issue
  a_rcv_after_iss: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rcv_en |-> rcv_r < iss_r)
    else $error("byte received without matching issue");

endmodule

[hw/rtl/lsb_first_bit_reader_top.sv]
// Top level of the LSB-first bit reader: byte FIFO in RAM, read window, result register.
// Depends on lbr_pkg, lbr_if, lbr_ram and lbr_ctrl.
//
//   channel | dir | handshake           | word
//   in_ch   | in  | valid/ready         | action, data_byte, bit_count, clear_buffer
//   out_ch  | out | valid/ready         | read_value, status, available_bits
//
// One word at a time. Push, align, reset and refused reads go from accept straight to commit.
// A successful read spans N bytes (1..9): after accept, one RAM read port
// fetches one byte per cycle, the registered read data fills the window, then commit.
// Reset (rst_n, synchronous) empties the FIFO and clears the bit offset; RAM
// contents are not cleared and need no clearing pass.
// The result register holds a word while out_ch stalls; the next input word
// is still accepted and waits at commit until the register frees.
module lsb_first_bit_reader_top
  import lbr_pkg::*;
#(
  parameter int STORE_DEPTH   = 256,
  parameter int MAX_READ_BITS = 64
) (
  input logic clk,
  input logic rst_n,
  lbr_in_if.sink    in_ch,
  lbr_out_if.source out_ch
);

  localparam int IW        = $clog2(STORE_DEPTH);
  localparam int CW        = $clog2(STORE_DEPTH + 1);
  localparam int WIN_BYTES = (MAX_READ_BITS + 14) / 8;
  localparam int ACC_W     = WIN_BYTES * 8;

  lbr_ctl_t ctl;

  // Architectural state
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    off_r, off_nxt;

  // Latched input word and decode
  lbr_act_t      act_r;
  logic [7:0]    data_r;
  logic [6:0]    n_r;
  logic          clear_r;
  lbr_status_t   status_r;
  logic [K_W-1:0] need_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r;
  lbr_status_t out_status_r;
  logic [11:0] out_avail_r;

  logic           in_fire;
  logic           slot_free;
  lbr_act_t       in_act;
  logic [7:0]     span8;
  logic [7:0]     need8;
  logic           bad_count;
  logic           short_data;
  lbr_status_t    dec_status;
  logic           go_read;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] acc_shift;
  logic [63:0]      mask;
  logic [63:0]      value;

  logic [IW:0]     rd_sum, tail_sum, head_sum;
  logic [IW-1:0]   rd_addr, tail_addr;
  logic [K_W-1:0]  pops;
  logic [2:0]      off_rd;
  logic [7:0]      rd_data;
  logic            mem_we;

  assign in_fire   = in_ch.valid && ctl.in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_act    = lbr_act_t'(in_ch.action);

  // Decode at accept: offset and count are stable while idle
  always_comb begin
    span8      = 8'(off_r) + 8'(in_ch.bit_count);
    need8      = (span8 + 8'd7) >> 3;
    bad_count  = (in_ch.bit_count == 7'd0) || (int'(in_ch.bit_count) > MAX_READ_BITS);
    short_data = 32'(count_r) < 32'(need8);
    dec_status = ST_OK;
    case (in_act)
      ACT_PUSH: begin
        if (32'(count_r) >= 32'(STORE_DEPTH)) begin
          dec_status = ST_FULL;
        end
      end
      ACT_READ: begin
        if (bad_count) begin
          dec_status = ST_BAD_COUNT;
        end else if (short_data) begin
          dec_status = ST_SHORT;
        end
      end
      default: dec_status = ST_OK;
    endcase
    go_read = (in_act == ACT_READ) && (dec_status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= in_act;
      data_r   <= in_ch.data_byte;
      n_r      <= in_ch.bit_count;
      clear_r  <= in_ch.clear_buffer;
      status_r <= dec_status;
      need_r   <= K_W'(need8);
    end
  end

  lbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .go_read   (go_read),
    .need_i    (need_r),
    .slot_free (slot_free),
    .ctl       (ctl)
  );

  // RAM addressing: read at head + k, write at head + count, both wrapped
  always_comb begin
    rd_sum    = (IW+1)'(head_r) + (IW+1)'(ctl.rd_k);
    rd_addr   = (rd_sum >= (IW+1)'(STORE_DEPTH)) ? IW'(rd_sum - (IW+1)'(STORE_DEPTH))
                                                 : IW'(rd_sum);
    tail_sum  = (IW+1)'(head_r) + (IW+1)'(count_r);
    tail_addr = (tail_sum >= (IW+1)'(STORE_DEPTH)) ? IW'(tail_sum - (IW+1)'(STORE_DEPTH))
                                                   : IW'(tail_sum);
  end

  // Writes only happen at commit, reads only in the fetch loop: no overlap
  assign mem_we = ctl.commit && (act_r == ACT_PUSH) && (status_r == ST_OK);

  lbr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_addr),
    .wdata (data_r),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Window assembly: byte k lands in lane k
  always_comb begin
    acc_nxt = acc_r;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (ctl.rcv_en && (ctl.rcv_k == K_W'(i))) begin
        acc_nxt[i*8 +: 8] = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Extract bits: drop the consumed offset, keep bit_count bits
  always_comb begin
    acc_shift = acc_r >> off_r;
    mask      = (n_r >= 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << n_r);
    value     = ((act_r == ACT_READ) && (status_r == ST_OK)) ? (64'(acc_shift) & mask)
                                                             : 64'd0;
  end

  // Commit: state update for the latched word
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    off_nxt   = off_r;
    off_rd    = off_r + n_r[2:0];
    pops      = '0;
    case (act_r)
      ACT_READ: begin
        if (status_r == ST_OK) begin
          pops    = need_r - K_W'(1) + K_W'(off_rd == 3'd0);
          off_nxt = off_rd;
        end
      end
      ACT_ALIGN: begin
        if ((off_r != 3'd0) && (count_r != '0)) begin
          pops = K_W'(1);
        end
        off_nxt = 3'd0;
      end
      default: pops = '0;
    endcase
    head_sum = (IW+1)'(head_r) + (IW+1)'(pops);
    head_nxt = (head_sum >= (IW+1)'(STORE_DEPTH)) ? IW'(head_sum - (IW+1)'(STORE_DEPTH))
                                                  : IW'(head_sum);
    count_nxt = count_r - CW'(pops);
    case (act_r)
      ACT_PUSH: begin
        if (status_r == ST_OK) begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_RESET: begin
        if (clear_r) begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        off_nxt = 3'd0;
      end
      default: off_nxt = off_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      off_r   <= 3'd0;
    end else if (ctl.commit) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      off_r   <= off_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_value_r  <= value;
      out_status_r <= status_r;
      out_avail_r  <= 12'({count_nxt, 3'b000});
    end
  end

  assign in_ch.ready           = ctl.in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_value     = out_value_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.available_bits = out_avail_r;

  // FIFO fill never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(STORE_DEPTH))
    else $error("byte count exceeds store depth");

  // Commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before taken");

  // Only a successful read carries data
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_value_r == 64'd0))
    else $error("nonzero value on refused word");

  // Bytes consumed by a read were held at accept
  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> 32'(pops) <= 32'(count_r))
    else $error("pop beyond held bytes");

endmodule
